[hdl/assert_macros.svh]
// assertion macros shared by the clipper rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

[hdl/tfc_pkg.sv]
// types and constants of the triangle frustum clipper
package tfc_pkg;

    localparam int DIV_STEPS = 31;
    localparam int REG_W     = 31;

    localparam logic [1:0] CFG_NEAR  = 2'd0;
    localparam logic [1:0] CFG_HSLOPE = 2'd1;
    localparam logic [1:0] CFG_VSLOPE = 2'd2;

    localparam logic [REG_W-1:0] NEAR_RESET   = 31'd6554;
    localparam logic [REG_W-1:0] HSLOPE_RESET = 31'd65536;
    localparam logic [REG_W-1:0] VSLOPE_RESET = 31'd49152;

    typedef enum logic [2:0] {
        PL_NEAR,
        PL_LEFT,
        PL_RIGHT,
        PL_TOP,
        PL_BOTTOM
    } plane_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_RD,
        S_MUL,
        S_ADD,
        S_DEC,
        S_DIV,
        S_LMUL,
        S_LFIN,
        S_WNEW,
        S_WCUR,
        S_NEXT,
        S_PEND,
        S_CULL,
        S_ERD,
        S_EOUT
    } state_t;

    // one step of the restoring divider
    typedef struct packed {
        logic        valid;
        logic [65:0] r;
        logic [64:0] den;
        logic [30:0] q;
    } div_stage_t;

endpackage

[hdl/tfc_div_cell.sv]
// one restoring division cell: compare, subtract, shift
module tfc_div_cell
    import tfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  div_stage_t in_stage,
    output div_stage_t out_stage
);

    logic        ge;
    logic [65:0] rem;
    logic        valid_reg;
    logic [65:0] r_reg;
    logic [64:0] den_reg;
    logic [30:0] q_reg;

    assign ge  = in_stage.r >= {1'b0, in_stage.den};
    assign rem = ge ? in_stage.r - {1'b0, in_stage.den} : in_stage.r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= {rem[64:0], 1'b0};
        den_reg <= in_stage.den;
        q_reg   <= {in_stage.q[29:0], ge};
    end

    assign out_stage = '{valid: valid_reg, r: r_reg, den: den_reg, q: q_reg};

endmodule

[hdl/tfc_div_chain.sv]
// row of division cells producing floor(num * 2^30 / den)
module tfc_div_chain
    import tfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [64:0] den,
    output div_stage_t  result
);

    div_stage_t stage [0:DIV_STEPS];

    assign stage[0] = '{valid: start, r: {2'b00, num}, den: den, q: '0};

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        tfc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_stage  (stage[i]),
            .out_stage (stage[i+1])
        );
    end

    assign result = stage[DIV_STEPS];

endmodule

[hdl/triangle_frustum_clipper.sv]
// top level of the triangle frustum clipper
//
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+--------------------------
// triangle  | ax ay az bx by bz cx cy cz                | start && !busy
// vertex    | vx vy vz vertex_index last culled         | strobe, one cycle, no stall
// config    | cfg_index cfg_data                        | cfg_we
//
// one triangle at a time; busy stays high until its last result is issued
// per plane: the last vertex is read as the previous one, then each vertex is read
// and tested; a crossing edge waits on the 31-cell divider chain and does three
// lerp multiplies on one shared multiplier; emit reads and issues each vertex
// reset clears control state and restores the config registers; results cannot stall
`include "assert_macros.svh"

module triangle_frustum_clipper
    import tfc_pkg::*;
#(
    parameter int MAX_POLY_VERTS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] ax,
    input  logic signed [31:0] ay,
    input  logic signed [31:0] az,
    input  logic signed [31:0] bx,
    input  logic signed [31:0] by,
    input  logic signed [31:0] bz,
    input  logic signed [31:0] cx,
    input  logic signed [31:0] cy,
    input  logic signed [31:0] cz,
    output logic               strobe,
    output logic signed [31:0] vx,
    output logic signed [31:0] vy,
    output logic signed [31:0] vz,
    output logic [2:0]         vertex_index,
    output logic               last,
    output logic               culled,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [REG_W-1:0]   cfg_data
);

    localparam int CW    = $clog2(MAX_POLY_VERTS + 1);
    localparam int DEPTH = 2 * MAX_POLY_VERTS;
    localparam int AW    = $clog2(DEPTH);

    state_t state_reg, state_next;

    // configuration
    logic [REG_W-1:0] near_reg, hslope_reg, vslope_reg;

    // two banks of polygon vertices
    logic [31:0] mem_x [DEPTH];
    logic [31:0] mem_y [DEPTH];
    logic [31:0] mem_z [DEPTH];
    logic [31:0] rd_x_reg, rd_y_reg, rd_z_reg;

    // control
    plane_t      plane_reg;
    logic        bank_reg;
    logic        first_reg;
    logic [CW-1:0] idx_reg, cnt_n_reg, out_cnt_reg, k_reg;
    logic [1:0]  coord_reg;
    logic        strobe_reg;

    // payload
    logic [31:0] in_x_reg [3];
    logic [31:0] in_y_reg [3];
    logic [31:0] in_z_reg [3];
    logic [31:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic [31:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic [31:0] new_x_reg, new_y_reg, new_z_reg;
    logic signed [63:0] prod_reg, fc_reg, fp_reg;
    logic [30:0] t_reg;
    logic [63:0] lprod_reg;
    logic        lneg_reg;
    logic [31:0] la_reg;
    logic [31:0] vx_reg, vy_reg, vz_reg;
    logic [2:0]  vidx_reg;
    logic        last_reg, culled_reg;

    logic [CW-1:0] rd_idx;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [31:0]   wr_x, wr_y, wr_z;
    logic [REG_W-1:0] slope;
    logic signed [63:0] dist_c, zn, xs, ys;
    logic          crossing;
    logic [63:0]   mag_p, mag_c;
    logic [64:0]   den;
    div_stage_t    div_out;
    logic [31:0]   a_sel, b_sel;
    logic [32:0]   d33, mag33;
    logic [63:0]   s64;
    logic [31:0]   lres;
    logic          room;

    function automatic logic [AW-1:0] vaddr(input logic bank, input logic [CW-1:0] idx);
        vaddr = bank ? AW'(MAX_POLY_VERTS) + AW'(idx) : AW'(idx);
    endfunction

    assign busy = state_reg != S_IDLE;

    // config writes, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg   <= NEAR_RESET;
            hslope_reg <= HSLOPE_RESET;
            vslope_reg <= VSLOPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NEAR:   near_reg   <= cfg_data;
                CFG_HSLOPE: hslope_reg <= cfg_data;
                CFG_VSLOPE: vslope_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // memory ports
    assign rd_idx  = (state_reg == S_ERD) ? k_reg : (first_reg ? cnt_n_reg - 1'b1 : idx_reg);
    assign rd_addr = vaddr(bank_reg, rd_idx);
    assign room    = out_cnt_reg < CW'(MAX_POLY_VERTS);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = vaddr(~bank_reg, out_cnt_reg);
        wr_x    = cur_x_reg;
        wr_y    = cur_y_reg;
        wr_z    = cur_z_reg;
        case (state_reg)
            S_LOAD:
            begin
                wr_en   = 1'b1;
                wr_addr = vaddr(1'b0, k_reg);
                wr_x    = in_x_reg[k_reg[1:0]];
                wr_y    = in_y_reg[k_reg[1:0]];
                wr_z    = in_z_reg[k_reg[1:0]];
            end
            S_WNEW:
            begin
                wr_en = room;
                wr_x  = new_x_reg;
                wr_y  = new_y_reg;
                wr_z  = new_z_reg;
            end
            S_WCUR:  wr_en = room;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
            mem_z[wr_addr] <= wr_z;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
        rd_z_reg <= mem_z[rd_addr];
    end

    // plane distance in units of 2^-32
    assign slope = (plane_reg == PL_LEFT || plane_reg == PL_RIGHT) ? hslope_reg : vslope_reg;
    assign zn    = {{32{cur_z_reg[31]}}, cur_z_reg} - {33'b0, near_reg};
    assign xs    = {{16{cur_x_reg[31]}}, cur_x_reg, 16'b0};
    assign ys    = {{16{cur_y_reg[31]}}, cur_y_reg, 16'b0};

    always_comb
    begin
        case (plane_reg)
            PL_NEAR:  dist_c = {zn[47:0], 16'b0};
            PL_LEFT:  dist_c = xs + prod_reg;
            PL_RIGHT: dist_c = prod_reg - xs;
            PL_TOP:   dist_c = prod_reg - ys;
            default:  dist_c = ys + prod_reg;
        endcase
    end

    // edge crossing and the interpolation ratio
    assign crossing = fp_reg[63] != fc_reg[63];
    assign mag_p    = fp_reg[63] ? 64'(-fp_reg) : 64'(fp_reg);
    assign mag_c    = fc_reg[63] ? 64'(-fc_reg) : 64'(fc_reg);
    assign den      = {1'b0, mag_p} + {1'b0, mag_c};

    tfc_div_chain u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_DEC && crossing),
        .num    (mag_p),
        .den    (den),
        .result (div_out)
    );

    // lerp from previous toward current vertex, one coordinate at a time
    always_comb
    begin
        case (coord_reg)
            2'd0:    begin a_sel = prev_x_reg; b_sel = cur_x_reg; end
            2'd1:    begin a_sel = prev_y_reg; b_sel = cur_y_reg; end
            default: begin a_sel = prev_z_reg; b_sel = cur_z_reg; end
        endcase
    end

    assign d33   = {b_sel[31], b_sel} - {a_sel[31], a_sel};
    assign mag33 = d33[32] ? -d33 : d33;
    assign s64   = (lprod_reg + (64'd1 << 29)) >> 30;
    assign lres  = lneg_reg ? la_reg - s64[31:0] : la_reg + s64[31:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_LOAD;
            S_LOAD: if (k_reg == CW'(2)) state_next = S_RD;
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_ADD;
            S_ADD:  state_next = first_reg ? S_RD : S_DEC;
            S_DEC:
            begin
                if (crossing)
                    state_next = S_DIV;
                else if (!fc_reg[63])
                    state_next = S_WCUR;
                else
                    state_next = S_NEXT;
            end
            S_DIV:  if (div_out.valid) state_next = S_LMUL;
            S_LMUL: state_next = S_LFIN;
            S_LFIN: state_next = (coord_reg == 2'd2) ? S_WNEW : S_LMUL;
            S_WNEW: state_next = fc_reg[63] ? S_NEXT : S_WCUR;
            S_WCUR: state_next = S_NEXT;
            S_NEXT: state_next = (idx_reg + 1'b1 == cnt_n_reg) ? S_PEND : S_RD;
            S_PEND:
            begin
                if (out_cnt_reg < CW'(3))
                    state_next = S_CULL;
                else if (plane_reg == PL_BOTTOM)
                    state_next = S_ERD;
                else
                    state_next = S_RD;
            end
            S_CULL: state_next = S_IDLE;
            S_ERD:  state_next = S_EOUT;
            S_EOUT: state_next = (k_reg + 1'b1 == cnt_n_reg) ? S_IDLE : S_ERD;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg   <= PL_NEAR;
            bank_reg    <= 1'b0;
            first_reg   <= 1'b0;
            idx_reg     <= '0;
            cnt_n_reg   <= '0;
            out_cnt_reg <= '0;
            k_reg       <= '0;
            coord_reg   <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        plane_reg   <= PL_NEAR;
                        bank_reg    <= 1'b0;
                        first_reg   <= 1'b1;
                        idx_reg     <= '0;
                        cnt_n_reg   <= CW'(3);
                        out_cnt_reg <= '0;
                        k_reg       <= '0;
                    end
                end
                S_LOAD: k_reg <= k_reg + 1'b1;
                S_ADD:
                begin
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        idx_reg   <= '0;
                    end
                end
                S_DIV:  coord_reg <= '0;
                S_LFIN: coord_reg <= coord_reg + 1'b1;
                S_WNEW, S_WCUR:
                begin
                    if (room)
                        out_cnt_reg <= out_cnt_reg + 1'b1;
                end
                S_NEXT: idx_reg <= idx_reg + 1'b1;
                S_PEND:
                begin
                    cnt_n_reg   <= out_cnt_reg;
                    out_cnt_reg <= '0;
                    bank_reg    <= ~bank_reg;
                    first_reg   <= 1'b1;
                    k_reg       <= '0;
                    if (plane_reg != PL_BOTTOM)
                        plane_reg <= plane_reg.next();
                end
                S_CULL: strobe_reg <= 1'b1;
                S_EOUT:
                begin
                    strobe_reg <= 1'b1;
                    k_reg      <= k_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                in_x_reg[0] <= ax; in_y_reg[0] <= ay; in_z_reg[0] <= az;
                in_x_reg[1] <= bx; in_y_reg[1] <= by; in_z_reg[1] <= bz;
                in_x_reg[2] <= cx; in_y_reg[2] <= cy; in_z_reg[2] <= cz;
            end
            S_MUL:
            begin
                cur_x_reg <= rd_x_reg;
                cur_y_reg <= rd_y_reg;
                cur_z_reg <= rd_z_reg;
                prod_reg  <= $signed(rd_z_reg) * $signed({1'b0, slope});
            end
            S_ADD:
            begin
                fc_reg <= dist_c;
                if (first_reg)
                begin
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                    prev_z_reg <= cur_z_reg;
                    fp_reg     <= dist_c;
                end
            end
            S_DIV:  t_reg <= div_out.q;
            S_LMUL:
            begin
                lprod_reg <= 64'(mag33) * 64'(t_reg);
                lneg_reg  <= d33[32];
                la_reg    <= a_sel;
            end
            S_LFIN:
            begin
                case (coord_reg)
                    2'd0:    new_x_reg <= lres;
                    2'd1:    new_y_reg <= lres;
                    default: new_z_reg <= lres;
                endcase
            end
            S_NEXT:
            begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
                prev_z_reg <= cur_z_reg;
                fp_reg     <= fc_reg;
            end
            S_CULL:
            begin
                vx_reg     <= '0;
                vy_reg     <= '0;
                vz_reg     <= '0;
                vidx_reg   <= '0;
                last_reg   <= 1'b1;
                culled_reg <= 1'b1;
            end
            S_EOUT:
            begin
                vx_reg     <= rd_x_reg;
                vy_reg     <= rd_y_reg;
                vz_reg     <= rd_z_reg;
                vidx_reg   <= k_reg[2:0];
                last_reg   <= (k_reg + 1'b1 == cnt_n_reg);
                culled_reg <= 1'b0;
            end
            default: ;
        endcase
    end

    assign strobe       = strobe_reg;
    assign vx           = vx_reg;
    assign vy           = vy_reg;
    assign vz           = vz_reg;
    assign vertex_index = vidx_reg;
    assign last         = last_reg;
    assign culled       = culled_reg;

    `ASSERT_IMPLIES(a_cull_form, clk, rst_n, strobe && culled, last && vx == 0 && vertex_index == 0, "culled result malformed")
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted triangle did not raise busy")
    `ASSERT_IMPLIES(a_div_when_waiting, clk, rst_n, div_out.valid, state_reg == S_DIV, "ratio arrived outside the wait state")
    `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, 1'b1, out_cnt_reg <= CW'(MAX_POLY_VERTS), "polygon count past capacity")

endmodule
